// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fcc_pkg.sv =====
// ---------------------------------------------------------------------------
// fcc_pkg
// Field widths, codes and state encoding of the cluster chain engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcc_pkg;

	localparam int MODE_W      = 2;
	localparam int LENGTH_W    = 14;
	localparam int CLUSTER_W   = 6;
	localparam int MAX_RESULTS = 64;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_WALK  = 2'd2
	} mode_t;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_SCAN  = 8'b0000_0100,
		ST_LINK  = 8'b0000_1000,
		ST_TERM  = 8'b0001_0000,
		ST_FREE  = 8'b0010_0000,
		ST_WALK  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

endpackage

// ===== rtl/fcc_if.sv =====
// ---------------------------------------------------------------------------
// fcc_if
// Request and response channels of the cluster chain engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fcc_in_if;
	logic                           valid;
	logic                           ready;
	logic [fcc_pkg::MODE_W-1:0]     mode;
	logic [fcc_pkg::LENGTH_W-1:0]   byte_length;
	logic [fcc_pkg::CLUSTER_W-1:0]  start_cluster;

	modport source (output valid, mode, byte_length, start_cluster, input ready);
	modport sink   (input valid, mode, byte_length, start_cluster, output ready);
endinterface

interface fcc_out_if;
	logic                           valid;
	logic                           ready;
	logic                           status;
	logic [fcc_pkg::CLUSTER_W-1:0]  cluster;
	logic                           last;

	modport source (output valid, status, cluster, last, input ready);
	modport sink   (input valid, status, cluster, last, output ready);
endinterface

// ===== rtl/fcc_ram.sv =====
// ---------------------------------------------------------------------------
// fcc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/fat_cluster_chain_engine.sv =====
// ---------------------------------------------------------------------------
// fat_cluster_chain_engine
// Allocation table of cluster links: allocate, free and walk cluster chains.
// Allocate: a scan counts free entries up to the length, a link pass chains
//   them ascending and marks the end; too few free ones give an error result.
//   One table read per cycle. Free: clears each chained entry, then responds.
// Walk: one result per cycle unless the output stalls; ready returns the cycle
//   after the final result. Reset: table clearing sweep, ready low meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fat_cluster_chain_engine #(
	parameter int FAT_ENTRIES   = 64,
	parameter int CLUSTER_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	fcc_in_if.sink     req,
	fcc_out_if.source  rsp
);

	localparam int IW = $clog2(FAT_ENTRIES);
	localparam int EW = IW + 1;
	localparam int CW = (IW > fcc_pkg::CLUSTER_W) ? IW : fcc_pkg::CLUSTER_W;
	localparam int AW = $clog2(CLUSTER_BYTES + (1 << fcc_pkg::LENGTH_W)) + 1;

	localparam logic [CW:0]   FAT_LIM  = (CW + 1)'(FAT_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(FAT_ENTRIES - 1);
	localparam logic [AW-1:0] CB_ADD   = AW'(CLUSTER_BYTES);
	localparam logic [EW-1:0] END_MARK = '1;
	localparam logic [fcc_pkg::RES_CNT_W-1:0] LAST_RES =
		fcc_pkg::RES_CNT_W'(fcc_pkg::MAX_RESULTS - 1);

	fcc_pkg::state_t state_q, state_d;

	logic [fcc_pkg::LENGTH_W-1:0]  len_q, len_d;
	logic [IW-1:0]                 idx_q, idx_d;
	logic [IW-1:0]                 prev_q, prev_d;
	logic [IW-1:0]                 first_q, first_d;
	logic [CW-1:0]                 cur_q, cur_d;
	logic [AW-1:0]                 acc_q, acc_d;
	logic [fcc_pkg::RES_CNT_W-1:0] k_q, k_d;
	logic                          res_status_q, res_status_d;
	logic [fcc_pkg::CLUSTER_W-1:0] res_cluster_q, res_cluster_d;

	logic                          o_valid_q;
	logic                          o_status_q;
	logic [fcc_pkg::CLUSTER_W-1:0] o_cluster_q;
	logic                          o_last_q;

	logic                          emit;
	logic                          emit_status;
	logic [fcc_pkg::CLUSTER_W-1:0] emit_cluster;
	logic                          emit_last;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic [IW-1:0] rd_addr;
	logic [EW-1:0] rd_data;

	logic [AW-1:0] acc_sum;
	logic [AW-1:0] len_ext;
	logic [CW-1:0] start_ext;
	logic [IW-1:0] idx_inc;
	logic          sum_reaches;
	logic          link_free;
	logic          link_end;
	logic          cur_in;
	logic          can_emit;
	logic          walk_stop;

	logic          st_read_only;
	logic          st_link;
	logic          st_walk;
	logic          st_term;

	fcc_ram #(
		.WIDTH (EW),
		.DEPTH (FAT_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Shared adder: byte count covered by the clusters taken so far.
	assign acc_sum     = acc_q + CB_ADD;
	assign len_ext     = AW'(len_q);
	assign sum_reaches = acc_sum >= len_ext;
	assign start_ext   = CW'(req.start_cluster);
	assign idx_inc     = (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
	assign link_free   = rd_data == '0;
	assign link_end    = rd_data == END_MARK;
	assign cur_in      = {1'b0, cur_q} < FAT_LIM;
	assign can_emit    = !o_valid_q || rsp.ready;
	assign walk_stop   = sum_reaches || (k_q == LAST_RES) || !cur_in || link_free || link_end;

	assign st_read_only = (state_q == fcc_pkg::ST_IDLE) || (state_q == fcc_pkg::ST_SCAN) ||
		(state_q == fcc_pkg::ST_WALK) || (state_q == fcc_pkg::ST_FIN);
	assign st_link      = state_q == fcc_pkg::ST_LINK;
	assign st_walk      = state_q == fcc_pkg::ST_WALK;
	assign st_term      = state_q == fcc_pkg::ST_TERM;

	assign req.ready   = state_q == fcc_pkg::ST_IDLE;
	assign rsp.valid   = o_valid_q;
	assign rsp.status  = o_status_q;
	assign rsp.cluster = o_cluster_q;
	assign rsp.last    = o_last_q;

	always_comb begin
		state_d       = state_q;
		len_d         = len_q;
		idx_d         = idx_q;
		prev_d        = prev_q;
		first_d       = first_q;
		cur_d         = cur_q;
		acc_d         = acc_q;
		k_d           = k_q;
		res_status_d  = res_status_q;
		res_cluster_d = res_cluster_q;
		rd_addr       = idx_q;
		wr_en         = 1'b0;
		wr_addr       = idx_q;
		wr_data       = '0;
		emit          = 1'b0;
		emit_status   = 1'b0;
		emit_cluster  = '0;
		emit_last     = 1'b0;

		unique case (state_q)
			fcc_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				idx_d = idx_inc;
				if (idx_q == LAST_IDX) begin
					state_d = fcc_pkg::ST_IDLE;
				end
			end
			fcc_pkg::ST_IDLE: begin
				if (req.valid) begin
					len_d         = req.byte_length;
					cur_d         = start_ext;
					idx_d         = '0;
					acc_d         = '0;
					k_d           = '0;
					res_status_d  = 1'b0;
					res_cluster_d = '0;
					unique case (fcc_pkg::mode_t'(req.mode))
						fcc_pkg::MODE_ALLOC: begin
							rd_addr = '0;
							state_d = fcc_pkg::ST_SCAN;
						end
						fcc_pkg::MODE_FREE: begin
							rd_addr = start_ext[IW-1:0];
							state_d = fcc_pkg::ST_FREE;
						end
						fcc_pkg::MODE_WALK: begin
							rd_addr = start_ext[IW-1:0];
							state_d = fcc_pkg::ST_WALK;
						end
						default: begin
							state_d = fcc_pkg::ST_FIN;
						end
					endcase
				end
			end
			fcc_pkg::ST_SCAN: begin
				// Count free entries until the length is covered; table untouched.
				if (link_free) begin
					acc_d = acc_sum;
				end
				if (link_free && sum_reaches) begin
					acc_d   = '0;
					idx_d   = '0;
					rd_addr = '0;
					state_d = fcc_pkg::ST_LINK;
				end else if (idx_q == LAST_IDX) begin
					res_status_d  = 1'b1;
					res_cluster_d = '0;
					state_d       = fcc_pkg::ST_FIN;
				end else begin
					idx_d   = idx_inc;
					rd_addr = idx_inc;
				end
			end
			fcc_pkg::ST_LINK: begin
				// Link each free entry from the previous one, ascending.
				if (link_free) begin
					acc_d  = acc_sum;
					prev_d = idx_q;
					if (acc_q == '0) begin
						first_d = idx_q;
					end else begin
						wr_en   = 1'b1;
						wr_addr = prev_q;
						wr_data = EW'(idx_q);
					end
					if (sum_reaches) begin
						state_d = fcc_pkg::ST_TERM;
					end
				end
				idx_d   = idx_inc;
				rd_addr = idx_inc;
			end
			fcc_pkg::ST_TERM: begin
				wr_en         = 1'b1;
				wr_addr       = prev_q;
				wr_data       = END_MARK;
				res_status_d  = 1'b0;
				res_cluster_d = fcc_pkg::CLUSTER_W'(first_q);
				state_d       = fcc_pkg::ST_FIN;
			end
			fcc_pkg::ST_FREE: begin
				if (!cur_in || link_free) begin
					state_d = fcc_pkg::ST_FIN;
				end else begin
					wr_en   = 1'b1;
					wr_addr = cur_q[IW-1:0];
					wr_data = '0;
					if (link_end) begin
						state_d = fcc_pkg::ST_FIN;
					end else begin
						cur_d   = CW'(rd_data[IW-1:0]);
						rd_addr = rd_data[IW-1:0];
					end
				end
			end
			fcc_pkg::ST_WALK: begin
				if (can_emit) begin
					emit         = 1'b1;
					emit_cluster = fcc_pkg::CLUSTER_W'(cur_q);
					emit_last    = walk_stop;
					k_d          = k_q + fcc_pkg::RES_CNT_W'(1);
					acc_d        = acc_sum;
					if (walk_stop) begin
						state_d = fcc_pkg::ST_IDLE;
					end else begin
						cur_d   = CW'(rd_data[IW-1:0]);
						rd_addr = rd_data[IW-1:0];
					end
				end else begin
					// Hold: re-read the current entry while the output stalls.
					rd_addr = cur_q[IW-1:0];
				end
			end
			fcc_pkg::ST_FIN: begin
				if (can_emit) begin
					emit         = 1'b1;
					emit_status  = res_status_q;
					emit_cluster = res_cluster_q;
					emit_last    = 1'b1;
					state_d      = fcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fcc_pkg::ST_CLEAR;
			idx_q     <= '0;
			acc_q     <= '0;
			k_q       <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
			k_q     <= k_d;
			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_q         <= len_d;
		prev_q        <= prev_d;
		first_q       <= first_d;
		cur_q         <= cur_d;
		res_status_q  <= res_status_d;
		res_cluster_q <= res_cluster_d;
		if (emit) begin
			o_status_q  <= emit_status;
			o_cluster_q <= emit_cluster;
			o_last_q    <= emit_last;
		end
	end

	`ASSERT_IMPLIES(a_no_write_when_reading_only, clk, arst_n, st_read_only, !wr_en)
	`ASSERT_IMPLIES(a_link_never_overruns, clk, arst_n, st_link, (acc_q == '0 || acc_q < len_ext))
	`ASSERT_IMPLIES(a_walk_count_bounded, clk, arst_n, st_walk, k_q <= LAST_RES)
	`ASSERT_NEXT(a_term_after_link, clk, arst_n, st_term, (state_q == fcc_pkg::ST_FIN && !res_status_q))

endmodule

// ===== test/fat_cluster_chain_engine_tb.sv =====
// ---------------------------------------------------------------------------
// fat_cluster_chain_engine_tb
// Drives allocate, free and walk requests into the cluster chain engine and
// checks every response against a cycle-free model of the link table. Both
// channels idle at random, the response side holds off once for a long
// stretch, and the request side pauses until all responses are in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_cluster_chain_engine_tb;

	localparam int         TABLE_DEPTH    = 64;
	localparam int         CLUSTER_BYTES  = 128;
	localparam int         ITEM_TARGET    = 480;
	localparam int         IDLE_PERCENT   = 38;
	localparam int         HOLDOFF_CYCLES = 300;
	localparam int         STALL_LIMIT    = 5000;
	localparam int         DRAIN_CYCLES   = 2 * TABLE_DEPTH + 20;
	localparam logic [1:0] MODE_UNUSED    = 2'd3;
	localparam logic [6:0] LINK_FREE      = 7'd0;
	localparam logic [6:0] LINK_END       = 7'h7F;

	typedef struct packed {
		logic [fcc_pkg::MODE_W-1:0]    mode;
		logic [fcc_pkg::LENGTH_W-1:0]  byte_length;
		logic [fcc_pkg::CLUSTER_W-1:0] start_cluster;
	} request_t;

	typedef struct packed {
		logic                          status;
		logic [fcc_pkg::CLUSTER_W-1:0] cluster;
		logic                          last;
	} response_t;

	logic clk;
	logic arst_n;

	fcc_in_if  req_bus ();
	fcc_out_if rsp_bus ();

	fat_cluster_chain_engine #(
		.FAT_ENTRIES   (TABLE_DEPTH),
		.CLUSTER_BYTES (CLUSTER_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	logic [6:0] chain_link [TABLE_DEPTH];
	request_t   pending_requests [$];
	response_t  expected_responses [$];
	response_t  want_rsp;
	int         mismatch_count;
	int         idle_cycles;
	int         holdoff_left;
	bit         holdoff_armed;
	bit         holdoff_done;
	bit         calm_stretch;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int clusters_needed(int len);
		if (len == 0)
			return 1;
		return (len + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
	endfunction

	// Update the link table for one transaction and queue its responses.
	function automatic void apply_request(request_t r);
		int         need;
		int         found;
		int         first;
		int         prev;
		int         cur;
		int         count;
		logic [6:0] nxt;
		bit         stop;
		first = 0;
		prev  = 0;
		found = 0;
		count = 0;
		case (r.mode)
			fcc_pkg::MODE_ALLOC: begin
				need = clusters_needed(r.byte_length);
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (chain_link[i] == LINK_FREE)
						found++;
				if (found < need) begin
					expected_responses.push_back('{1'b1, '0, 1'b1});
				end else begin
					found = 0;
					for (int i = 0; i < TABLE_DEPTH && found < need; i++) begin
						if (chain_link[i] == LINK_FREE) begin
							if (found == 0)
								first = i;
							else
								chain_link[prev] = 7'(i);
							prev = i;
							found++;
						end
					end
					chain_link[prev] = LINK_END;
					expected_responses.push_back('{1'b0, fcc_pkg::CLUSTER_W'(first), 1'b1});
				end
			end
			fcc_pkg::MODE_FREE: begin
				cur = r.start_cluster;
				for (int steps = 0; steps < TABLE_DEPTH; steps++) begin
					if (cur >= TABLE_DEPTH)
						break;
					nxt = chain_link[cur];
					if (nxt == LINK_FREE)
						break;
					chain_link[cur] = LINK_FREE;
					if (nxt == LINK_END)
						break;
					cur = nxt;
				end
				expected_responses.push_back('{1'b0, '0, 1'b1});
			end
			fcc_pkg::MODE_WALK: begin
				need = clusters_needed(r.byte_length);
				if (need > fcc_pkg::MAX_RESULTS)
					need = fcc_pkg::MAX_RESULTS;
				cur = r.start_cluster;
				while (1'b1) begin
					count++;
					stop = (count >= need) || (cur >= TABLE_DEPTH);
					nxt  = LINK_FREE;
					if (!stop) begin
						nxt  = chain_link[cur];
						stop = (nxt == LINK_END) || (nxt == LINK_FREE);
					end
					expected_responses.push_back('{1'b0, fcc_pkg::CLUSTER_W'(cur), stop});
					if (stop)
						break;
					cur = nxt;
				end
			end
			default: begin
				expected_responses.push_back('{1'b0, '0, 1'b1});
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic int idle_percent();
		return calm_stretch ? 0 : IDLE_PERCENT;
	endfunction

	// Request driver: hold the transaction until accepted, then advance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid         <= 1'b0;
			req_bus.mode          <= '0;
			req_bus.byte_length   <= '0;
			req_bus.start_cluster <= '0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				apply_request(pending_requests.pop_front());
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= idle_percent()) begin
					req_bus.valid         <= 1'b1;
					req_bus.mode          <= pending_requests[0].mode;
					req_bus.byte_length   <= pending_requests[0].byte_length;
					req_bus.start_cluster <= pending_requests[0].start_cluster;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and ready generator.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			holdoff_left  <= 0;
			holdoff_done  <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("unexpected response, cluster", rsp_bus.cluster, 0);
				end else begin
					want_rsp = expected_responses.pop_front();
					if (rsp_bus.status !== want_rsp.status)
						report_mismatch("status", rsp_bus.status, want_rsp.status);
					if (rsp_bus.cluster !== want_rsp.cluster)
						report_mismatch("cluster", rsp_bus.cluster, want_rsp.cluster);
					if (rsp_bus.last !== want_rsp.last)
						report_mismatch("last", rsp_bus.last, want_rsp.last);
				end
			end
			if (holdoff_left != 0) begin
				rsp_bus.ready <= 1'b0;
				holdoff_left  <= holdoff_left - 1;
			end else if (holdoff_armed && !holdoff_done) begin
				rsp_bus.ready <= 1'b0;
				holdoff_left  <= HOLDOFF_CYCLES;
				holdoff_done  <= 1'b1;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= idle_percent());
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("fat_cluster_chain_engine: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic queue_request(logic [1:0] mode, int len, int start);
		while (pending_requests.size() > 2)
			@(negedge clk);
		pending_requests.push_back('{mode, fcc_pkg::LENGTH_W'(len), fcc_pkg::CLUSTER_W'(start)});
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || req_bus.valid || expected_responses.size() != 0)
			@(negedge clk);
	endtask

	// Mostly pick a cluster that is in use, so walks and frees follow chains.
	function automatic int pick_start();
		int base;
		int idx;
		base = $urandom_range(TABLE_DEPTH - 1);
		if ($urandom_range(99) < 75)
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				idx = (base + i) % TABLE_DEPTH;
				if (chain_link[idx] != LINK_FREE)
					return idx;
			end
		return base;
	endfunction

	function automatic int random_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 75)
			return $urandom_range(1024);
		if (pick < 95)
			return $urandom_range(8192);
		case ($urandom_range(6))
			0: return 0;
			1: return 1;
			2: return 127;
			3: return 128;
			4: return 129;
			5: return 8192;
			default: return 16383;
		endcase
	endfunction

	initial begin
		int pick;
		mismatch_count = 0;
		holdoff_armed  = 1'b0;
		calm_stretch   = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			chain_link[i] = LINK_FREE;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fresh table, edge lengths, broken chains, full table
		queue_request(fcc_pkg::MODE_WALK, 0, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 0, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 1, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 128, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 129, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 1000, 0);
		queue_request(fcc_pkg::MODE_WALK, 1000, 5);
		queue_request(fcc_pkg::MODE_WALK, 8192, 5);
		queue_request(fcc_pkg::MODE_WALK, 300, 5);
		queue_request(fcc_pkg::MODE_FREE, 0, 3);
		queue_request(fcc_pkg::MODE_WALK, 200, 3);
		queue_request(fcc_pkg::MODE_ALLOC, 8192, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 16383, 0);
		queue_request(fcc_pkg::MODE_ALLOC, 384, 0);
		queue_request(fcc_pkg::MODE_WALK, 8191, 3);
		queue_request(fcc_pkg::MODE_FREE, 0, 6);
		queue_request(fcc_pkg::MODE_WALK, 8192, 5);
		queue_request(MODE_UNUSED, 16383, 63);
		queue_request(fcc_pkg::MODE_FREE, 0, 0);
		queue_request(fcc_pkg::MODE_FREE, 0, 1);
		queue_request(fcc_pkg::MODE_FREE, 0, 2);
		queue_request(fcc_pkg::MODE_FREE, 0, 3);
		queue_request(fcc_pkg::MODE_FREE, 0, 5);
		queue_request(fcc_pkg::MODE_ALLOC, 8192, 0);
		queue_request(fcc_pkg::MODE_WALK, 8192, 0);
		queue_request(fcc_pkg::MODE_FREE, 0, 0);
		drain();

		for (int n = 26; n < ITEM_TARGET; n++) begin
			if (n == 150)
				calm_stretch = 1'b1;
			if (n == 230)
				calm_stretch = 1'b0;
			if (n == 400)
				drain();
			if (n >= 300 && n < 312) begin
				// long walks while the response side is held off
				if (n == 301)
					holdoff_armed = 1'b1;
				queue_request(fcc_pkg::MODE_WALK, 8192, pick_start());
				continue;
			end
			pick = $urandom_range(99);
			if (pick < 35)
				queue_request(fcc_pkg::MODE_ALLOC, random_length(), $urandom_range(63));
			else if (pick < 62)
				queue_request(fcc_pkg::MODE_WALK, random_length(), pick_start());
			else if (pick < 95)
				queue_request(fcc_pkg::MODE_FREE, random_length(), pick_start());
			else
				queue_request(MODE_UNUSED, $urandom_range(16383), $urandom_range(63));
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_responses.size() == 0)
			$display("fat_cluster_chain_engine: match");
		else
			$display("fat_cluster_chain_engine: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fcc_pkg.sv
rtl/fcc_if.sv
rtl/fcc_ram.sv
rtl/fat_cluster_chain_engine.sv
test/fat_cluster_chain_engine_tb.sv
